@@ rtl/sefp_pkg.sv @@
// Shared types and constants for the event fragment parser.
// Beat structs for the byte and record channels, register and kind codes.
// No dependencies.
`default_nettype none

package sefp_pkg;

    // Largest number of channel records one fragment may carry
    localparam int MAX_CHANNELS = 64;
    // Active channel count from an eight-byte mask reaches 64 at most
    localparam int CNT_W = 7;

    localparam logic [7:0] BOARD_RESET = 8'hFF;

    typedef enum logic [2:0] {
        CFG_TIME_FORMAT    = 3'd0,
        CFG_HIGH_GAIN_FLAG = 3'd1,
        CFG_LOW_GAIN_FLAG  = 3'd2,
        CFG_ARRIVAL_FLAG   = 3'd3,
        CFG_OVER_TIME_FLAG = 3'd4,
        CFG_EXPECTED_CHANS = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_HEADER   = 2'd0,
        KIND_CHANNEL  = 2'd1,
        KIND_MISMATCH = 2'd2
    } record_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       fragment_start;
    } frag_beat_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] event_size;
        logic [7:0]  board_id;
        logic [63:0] time_stamp_bits;
        logic [63:0] trigger_id;
        logic [7:0]  channel_id;
        logic [15:0] high_gain;
        logic [15:0] low_gain;
        logic [31:0] arrival_time;
        logic [31:0] over_time;
        logic [3:0]  fields_present;
        logic        last_record;
    } rec_beat_t;

endpackage : sefp_pkg

`default_nettype wire

@@ rtl/sipm_event_fragment_parser.sv @@
// Event fragment parser: byte-wise header and channel record decoder.
// Depends on sefp_pkg for beat structs, register and kind codes.
//
// Usage
//   frag_*  : one stream byte per beat, fragment_start marks the first byte of
//             a fragment and restarts the parse, dropping any partial fragment.
//   rec_*   : one record per beat. A header record (kind header, or mismatch
//             when the mask popcount differs from expected_channels) follows
//             the last mask byte; then one channel record per active channel.
//             Channel records repeat the header fields of their fragment.
//   cfg_*   : register writes, taken in every cycle (cfg_ready is tied high).
//             Write only while idle; time_format is sampled on the start byte.
// Throughput
//   One byte per cycle while frag_ready is high. A record is registered on
//   the edge that accepts the byte which completes it. The parse state
//   update is a single pass from the state registers to the record register.
// Reset
//   rst_n clears the parse state and restores the register defaults; bytes
//   seen before the first start byte are ignored.
// Stall
//   A two-entry output (record register plus skid) takes one more record while
//   rec_ready is low; frag_ready drops only while the skid entry is full.
`default_nettype none

module sipm_event_fragment_parser
    import sefp_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,

    input  wire        frag_valid,
    output logic       frag_ready,
    input  wire frag_beat_t frag_beat,

    output logic       rec_valid,
    input  wire        rec_ready,
    output rec_beat_t  rec_beat,

    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [2:0]  cfg_index,
    input  wire [7:0]  cfg_data
);

    typedef enum logic [12:0] {
        PH_IDLE  = 13'b0000000000001,
        PH_SIZE  = 13'b0000000000010,
        PH_BOARD = 13'b0000000000100,
        PH_STAMP = 13'b0000000001000,
        PH_TRIG  = 13'b0000000010000,
        PH_MASK  = 13'b0000000100000,
        PH_CHID  = 13'b0000001000000,
        PH_TYPE  = 13'b0000010000000,
        PH_HG    = 13'b0000100000000,
        PH_LG    = 13'b0001000000000,
        PH_TOA   = 13'b0010000000000,
        PH_TOT   = 13'b0100000000000,
        PH_DONE  = 13'b1000000000000
    } phase_t;

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++) begin
            c = c + {3'b000, v[i]};
        end
        return c;
    endfunction

    // Configuration registers
    logic             time_format_reg;
    logic [7:0]       high_gain_flag_reg;
    logic [7:0]       low_gain_flag_reg;
    logic [7:0]       arrival_flag_reg;
    logic [7:0]       over_time_flag_reg;
    logic [CNT_W-1:0] expected_channels_reg;

    // Parse state
    phase_t           phase_reg, phase_next;
    logic [2:0]       byte_idx_reg, byte_idx_next;
    logic [15:0]      size_reg, size_next;
    logic [7:0]       board_reg, board_next;
    logic [63:0]      stamp_reg, stamp_next;
    logic [63:0]      trigger_reg, trigger_next;
    logic [CNT_W-1:0] active_reg, active_next;
    logic [CNT_W-1:0] chan_left_reg, chan_left_next;
    logic [7:0]       chan_reg, chan_next;
    logic [15:0]      gain_high_reg, gain_high_next;
    logic [15:0]      gain_low_reg, gain_low_next;
    logic [31:0]      arrival_reg, arrival_next;
    logic [31:0]      over_reg, over_next;
    logic             fmt_reg, fmt_next;
    logic [3:0]       present_reg, present_next;

    // Output register and skid entry
    logic             out_valid_reg;
    rec_beat_t        out_reg;
    logic             skid_valid_reg;
    rec_beat_t        skid_reg;

    // Single-pass decode signals
    logic             accept;
    logic             start;
    logic [7:0]       d;
    phase_t           ph;
    logic [2:0]       bi;
    logic             produce;
    rec_beat_t        res;
    logic             do_adv;
    logic             do_emit;
    logic [2:0]       adv_from;
    logic [3:0]       slot_mask;
    logic             pop;

    assign cfg_ready  = 1'b1;
    assign frag_ready = ~skid_valid_reg;
    assign accept     = frag_valid & frag_ready;
    assign pop        = out_valid_reg & rec_ready;
    assign rec_valid  = out_valid_reg;
    assign rec_beat   = out_reg;

    always_comb
    begin
        start = frag_beat.fragment_start;
        d     = frag_beat.data_byte;

        // A start byte restarts the header before the byte itself is parsed
        ph             = start ? PH_SIZE : phase_reg;
        bi             = start ? 3'd0 : byte_idx_reg;
        phase_next     = ph;
        byte_idx_next  = bi;
        size_next      = start ? 16'd0 : size_reg;
        board_next     = start ? BOARD_RESET : board_reg;
        stamp_next     = start ? 64'd0 : stamp_reg;
        trigger_next   = start ? 64'd0 : trigger_reg;
        active_next    = start ? '0 : active_reg;
        chan_left_next = start ? '0 : chan_left_reg;
        fmt_next       = start ? time_format_reg : fmt_reg;
        chan_next      = chan_reg;
        gain_high_next = gain_high_reg;
        gain_low_next  = gain_low_reg;
        arrival_next   = arrival_reg;
        over_next      = over_reg;
        present_next   = present_reg;

        produce   = 1'b0;
        res       = '0;
        do_adv    = 1'b0;
        do_emit   = 1'b0;
        adv_from  = 3'd0;
        slot_mask = 4'd0;

        case (ph)
            PH_SIZE:
            begin
                size_next[{bi[0], 3'b000} +: 8] = d;
                if (bi >= 3'd1)
                begin
                    phase_next    = PH_BOARD;
                    byte_idx_next = 3'd0;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_BOARD:
            begin
                board_next    = d;
                phase_next    = PH_STAMP;
                byte_idx_next = 3'd0;
            end
            PH_STAMP:
            begin
                stamp_next[{bi, 3'b000} +: 8] = d;
                if (bi == 3'd7)
                begin
                    phase_next    = PH_TRIG;
                    byte_idx_next = 3'd0;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_TRIG:
            begin
                trigger_next[{bi, 3'b000} +: 8] = d;
                if (bi == 3'd7)
                begin
                    phase_next    = PH_MASK;
                    byte_idx_next = 3'd0;
                    active_next   = '0;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_MASK:
            begin
                active_next = active_next + {{(CNT_W-4){1'b0}}, popcount8(d)};
                if (bi != 3'd7)
                begin
                    byte_idx_next = bi + 3'd1;
                end
                else
                begin
                    chan_left_next = (active_next > CNT_W'(MAX_CHANNELS))
                                   ? CNT_W'(MAX_CHANNELS) : active_next;
                    produce             = 1'b1;
                    res.record_kind     = (active_next != expected_channels_reg)
                                        ? KIND_MISMATCH : KIND_HEADER;
                    res.last_record     = (chan_left_next == '0);
                    phase_next          = (chan_left_next == '0) ? PH_DONE : PH_CHID;
                    byte_idx_next       = 3'd0;
                end
            end
            PH_CHID:
            begin
                chan_next  = d;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                present_next   = {|(d & over_time_flag_reg), |(d & arrival_flag_reg),
                                  |(d & low_gain_flag_reg),  |(d & high_gain_flag_reg)};
                gain_high_next = 16'd0;
                gain_low_next  = 16'd0;
                arrival_next   = 32'd0;
                over_next      = 32'd0;
                do_adv         = 1'b1;
                adv_from       = 3'd0;
            end
            PH_HG:
            begin
                gain_high_next[{bi[0], 3'b000} +: 8] = d;
                if (bi >= 3'd1)
                begin
                    do_adv   = 1'b1;
                    adv_from = 3'd1;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_LG:
            begin
                gain_low_next[{bi[0], 3'b000} +: 8] = d;
                if (bi >= 3'd1)
                begin
                    do_adv   = 1'b1;
                    adv_from = 3'd2;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_TOA:
            begin
                arrival_next[{bi[1:0], 3'b000} +: 8] = d;
                if (bi >= 3'd3)
                begin
                    do_adv   = 1'b1;
                    adv_from = 3'd3;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            PH_TOT:
            begin
                over_next[{bi[1:0], 3'b000} +: 8] = d;
                if (bi >= (fmt_next ? 3'd3 : 3'd1))
                begin
                    do_adv   = 1'b1;
                    adv_from = 3'd4;
                end
                else
                begin
                    byte_idx_next = bi + 3'd1;
                end
            end
            default:
            begin
                // Idle before any start, or done: drop the byte
            end
        endcase

        // Advance to the first present field at or after adv_from, else emit
        if (do_adv)
        begin
            slot_mask     = present_next & ~((4'b0001 << adv_from) - 4'b0001);
            byte_idx_next = 3'd0;
            if (slot_mask[0])
            begin
                phase_next = PH_HG;
            end
            else if (slot_mask[1])
            begin
                phase_next = PH_LG;
            end
            else if (slot_mask[2])
            begin
                phase_next = PH_TOA;
            end
            else if (slot_mask[3])
            begin
                phase_next = PH_TOT;
            end
            else
            begin
                do_emit = 1'b1;
            end
        end

        if (do_emit)
        begin
            chan_left_next     = chan_left_next - CNT_W'(1);
            produce            = 1'b1;
            res.record_kind    = KIND_CHANNEL;
            res.last_record    = (chan_left_next == '0);
            res.channel_id     = chan_next;
            res.high_gain      = gain_high_next;
            res.low_gain       = gain_low_next;
            res.arrival_time   = arrival_next;
            res.over_time      = over_next;
            res.fields_present = present_next;
            phase_next         = (chan_left_next == '0) ? PH_DONE : PH_CHID;
            byte_idx_next      = 3'd0;
        end

        // Header fields ride on every record of the fragment
        if (produce)
        begin
            res.event_size      = size_next;
            res.board_id        = board_next;
            res.time_stamp_bits = stamp_next;
            res.trigger_id      = trigger_next;
        end
    end

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_format_reg       <= 1'b0;
            high_gain_flag_reg    <= 8'd1;
            low_gain_flag_reg     <= 8'd2;
            arrival_flag_reg      <= 8'd16;
            over_time_flag_reg    <= 8'd32;
            expected_channels_reg <= CNT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIME_FORMAT:    time_format_reg       <= cfg_data[0];
                CFG_HIGH_GAIN_FLAG: high_gain_flag_reg    <= cfg_data;
                CFG_LOW_GAIN_FLAG:  low_gain_flag_reg     <= cfg_data;
                CFG_ARRIVAL_FLAG:   arrival_flag_reg      <= cfg_data;
                CFG_OVER_TIME_FLAG: over_time_flag_reg    <= cfg_data;
                CFG_EXPECTED_CHANS: expected_channels_reg <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Parse state: advance once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            byte_idx_reg  <= 3'd0;
            size_reg      <= 16'd0;
            board_reg     <= BOARD_RESET;
            stamp_reg     <= 64'd0;
            trigger_reg   <= 64'd0;
            active_reg    <= '0;
            chan_left_reg <= '0;
            chan_reg      <= 8'd0;
            gain_high_reg <= 16'd0;
            gain_low_reg  <= 16'd0;
            arrival_reg   <= 32'd0;
            over_reg      <= 32'd0;
            fmt_reg       <= 1'b0;
            present_reg   <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            byte_idx_reg  <= byte_idx_next;
            size_reg      <= size_next;
            board_reg     <= board_next;
            stamp_reg     <= stamp_next;
            trigger_reg   <= trigger_next;
            active_reg    <= active_next;
            chan_left_reg <= chan_left_next;
            chan_reg      <= chan_next;
            gain_high_reg <= gain_high_next;
            gain_low_reg  <= gain_low_next;
            arrival_reg   <= arrival_next;
            over_reg      <= over_next;
            fmt_reg       <= fmt_next;
            present_reg   <= present_next;
        end
    end

    // Output valids: skid refills the record register first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept && produce)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept && produce)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

`ifndef ASSERT_OFF
    // The skid entry is only ever behind a held record
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid without a record in the output register");

    // The skid fills only when the record register was stalled
    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !rec_ready))
        else $error("skid filled while the output register was free");

    // A final channel record leaves the parser done with the fragment
    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && do_emit && res.last_record) |=> (phase_reg == PH_DONE))
        else $error("parser not done after the last channel record");

    // Remaining channel count never exceeds the cap
    a_chan_left_cap: assert property (@(posedge clk) disable iff (!rst_n)
        chan_left_reg <= CNT_W'(MAX_CHANNELS))
        else $error("remaining channel count above the cap");
`endif

endmodule : sipm_event_fragment_parser

`default_nettype wire
